/* rtl/core/zlre_pkg.sv */
package zlre_pkg;

  // Largest literal run the store holds
  localparam int MaxLiteralsDefault = 255;

  // Entries in the command queue between front and back
  localparam int CmdQueueDepth = 4;

  // Configuration port
  localparam int PaddrW = 3;
  localparam logic [PaddrW-1:0] AddrMaxRun = 3'd0;
  localparam logic [7:0] MaxRunReset = 8'd255;

  // One encoding command: an optional count byte, an optional literal burst
  // (count byte followed by that many stored literals) and up to two trailing bytes
  typedef struct packed {
    logic       last;
    logic       pre_en;
    logic [7:0] pre_byte;
    logic       burst_en;
    logic [7:0] burst_len;
    logic [1:0] post_cnt;
    logic [7:0] post0;
    logic [7:0] post1;
  } cmd_t;

  // Byte sequencer of the back end
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_PRE,
    SEQ_CNT,
    SEQ_LIT,
    SEQ_POST0,
    SEQ_POST1
  } seq_state_e;

endpackage

/* rtl/core/zlre_ram.sv */
module zlre_ram import zlre_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = MaxLiteralsDefault
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/zlre_cmd_fifo.sv */
module zlre_cmd_fifo import zlre_pkg::*; #(
  parameter int Depth = CmdQueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* rtl/core/zlre_front.sv */
module zlre_front import zlre_pkg::*; #(
  parameter int MaxLiterals = MaxLiteralsDefault
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic [7:0]                                   max_run_i,
  input  logic                                         in_valid_i,
  output logic                                         in_stall_o,
  input  logic [7:0]                                   data_byte_i,
  input  logic                                         last_byte_i,
  input  logic                                         q_full_i,
  output logic                                         push_o,
  output cmd_t                                         cmd_o,
  input  logic                                         burst_done_i,
  output logic                                         we_o,
  output logic [((MaxLiterals > 1) ? $clog2(MaxLiterals) : 1)-1:0] waddr_o,
  output logic [7:0]                                   wdata_o
);

  localparam int LitAw = (MaxLiterals > 1) ? $clog2(MaxLiterals) : 1;
  localparam logic [7:0] LitCap = 8'(MaxLiterals);

  logic       phase_q, phase_d;
  logic [7:0] rl_q, rl_d;
  logic       burst_out_q, burst_out_d;
  logic [7:0] zcap, lcap, rl_inc;
  logic       accept;
  cmd_t       cmd;

  // Run caps: a zero cap acts as one
  assign zcap   = (max_run_i == 8'd0) ? 8'd1 : max_run_i;
  assign lcap   = (zcap < LitCap) ? zcap : LitCap;
  assign rl_inc = rl_q + 8'd1;

  // Hold input while a literal burst is outstanding or the queue is full
  assign in_stall_o = burst_out_q || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Classify the byte into a command and the next phase and run length
  always_comb begin
    cmd      = '0;
    cmd.last = last_byte_i;
    phase_d  = phase_q;
    rl_d     = rl_q;
    we_o     = 1'b0;
    waddr_o  = '0;
    if (!phase_q) begin
      if (data_byte_i == 8'd0) begin
        rl_d = rl_inc;
        if (rl_inc >= zcap) begin
          cmd.pre_en   = 1'b1;
          cmd.pre_byte = rl_inc;
          phase_d      = 1'b1;
          rl_d         = 8'd0;
        end
      end else begin
        cmd.pre_en   = 1'b1;
        cmd.pre_byte = rl_q;
        we_o         = 1'b1;
        phase_d      = 1'b1;
        rl_d         = 8'd1;
        if (lcap == 8'd1) begin
          cmd.burst_en  = 1'b1;
          cmd.burst_len = 8'd1;
          phase_d       = 1'b0;
          rl_d          = 8'd0;
        end
      end
    end else begin
      if (data_byte_i != 8'd0) begin
        we_o    = 1'b1;
        waddr_o = rl_q[LitAw-1:0];
        rl_d    = rl_inc;
        if (rl_inc >= lcap) begin
          cmd.burst_en  = 1'b1;
          cmd.burst_len = rl_inc;
          phase_d       = 1'b0;
          rl_d          = 8'd0;
        end
      end else begin
        cmd.burst_en  = 1'b1;
        cmd.burst_len = rl_q;
        phase_d       = 1'b0;
        rl_d          = 8'd1;
        if (zcap == 8'd1) begin
          cmd.post_cnt = 2'd1;
          cmd.post0    = 8'd1;
          phase_d      = 1'b1;
          rl_d         = 8'd0;
        end
      end
    end

    // Flush the open pair on the final byte of the block
    if (last_byte_i) begin
      if (!phase_d) begin
        if (rl_d != 8'd0) begin
          cmd.post_cnt = 2'd2;
          cmd.post0    = rl_d;
          cmd.post1    = 8'd0;
        end
      end else if (rl_d != 8'd0) begin
        cmd.burst_en  = 1'b1;
        cmd.burst_len = rl_d;
      end else if (cmd.post_cnt == 2'd0) begin
        cmd.post_cnt = 2'd1;
        cmd.post0    = 8'd0;
      end else begin
        cmd.post_cnt = 2'd2;
        cmd.post1    = 8'd0;
      end
      phase_d = 1'b0;
      rl_d    = 8'd0;
    end
  end

  assign cmd_o   = cmd;
  assign push_o  = accept && (cmd.pre_en || cmd.burst_en || (cmd.post_cnt != 2'd0));
  assign wdata_o = data_byte_i;

  // Track the single literal burst allowed in flight
  always_comb begin
    burst_out_d = burst_out_q;
    if (push_o && cmd.burst_en) begin
      burst_out_d = 1'b1;
    end else if (burst_done_i) begin
      burst_out_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      rl_q        <= 8'd0;
      burst_out_q <= 1'b0;
    end else begin
      burst_out_q <= burst_out_d;
      if (accept) begin
        phase_q <= phase_d;
        rl_q    <= rl_d;
      end
    end
  end

  // Write the literal store on accepted transactions only
  // (we_o is qualified by accept at the top level)

endmodule

/* rtl/core/zlre_back.sv */
module zlre_back import zlre_pkg::*; #(
  parameter int MaxLiterals = MaxLiteralsDefault
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         q_empty_i,
  input  cmd_t                                         q_cmd_i,
  output logic                                         pop_o,
  output logic                                         burst_done_o,
  output logic                                         re_o,
  output logic [((MaxLiterals > 1) ? $clog2(MaxLiterals) : 1)-1:0] raddr_o,
  input  logic [7:0]                                   rdata_i,
  output logic                                         out_valid_o,
  input  logic                                         out_stall_i,
  output logic [63:0]                                  packed_bytes_o,
  output logic [3:0]                                   byte_count_o,
  output logic                                         run_last_o,
  output logic                                         block_end_o
);

  localparam int LitAw = (MaxLiterals > 1) ? $clog2(MaxLiterals) : 1;

  function automatic seq_state_e after_lit(cmd_t c);
    return (c.post_cnt != 2'd0) ? SEQ_POST0 : SEQ_IDLE;
  endfunction

  function automatic seq_state_e after_cnt(cmd_t c);
    return (c.burst_len != 8'd0) ? SEQ_LIT : after_lit(c);
  endfunction

  function automatic seq_state_e after_pre(cmd_t c);
    return c.burst_en ? SEQ_CNT : after_lit(c);
  endfunction

  function automatic seq_state_e first_state(cmd_t c);
    return c.pre_en ? SEQ_PRE : after_pre(c);
  endfunction

  seq_state_e state_q, state_d, nxt;
  cmd_t       cmd_q, cmd_d;
  logic [7:0] lit_idx_q, lit_idx_d;

  // Byte stage between sequencer and packer
  logic       bs_valid_q, bs_ram_q, bs_end_q, bs_last_q;
  logic [7:0] bs_byte_q;
  logic       bs_ready, gen;
  logic [7:0] gen_byte;
  logic       gen_ram;

  // Packer and output register
  logic [63:0] acc_word_q;
  logic [2:0]  acc_cnt_q;
  logic [63:0] merged;
  logic [7:0]  byte_in;
  logic        fin, out_free, byte_take;
  logic        out_valid_q;
  logic [63:0] out_word_q;
  logic [3:0]  out_cnt_q;
  logic        out_run_last_q, out_block_end_q;

  assign byte_in   = bs_ram_q ? rdata_i : bs_byte_q;
  assign fin       = bs_end_q || (acc_cnt_q == 3'd7);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign byte_take = bs_valid_q && (!fin || out_free);
  assign bs_ready  = !bs_valid_q || byte_take;

  // Sequencer: next state and byte generation
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    lit_idx_d    = lit_idx_q;
    nxt          = SEQ_IDLE;
    pop_o        = 1'b0;
    gen          = 1'b0;
    gen_byte     = 8'd0;
    gen_ram      = 1'b0;
    burst_done_o = 1'b0;
    case (state_q)
      SEQ_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = q_cmd_i;
          state_d = first_state(q_cmd_i);
        end
      end
      SEQ_PRE: begin
        gen_byte = cmd_q.pre_byte;
        nxt      = after_pre(cmd_q);
      end
      SEQ_CNT: begin
        gen_byte = cmd_q.burst_len;
        nxt      = after_cnt(cmd_q);
      end
      SEQ_LIT: begin
        gen_ram = 1'b1;
        nxt     = ((lit_idx_q + 8'd1) == cmd_q.burst_len) ? after_lit(cmd_q) : SEQ_LIT;
      end
      SEQ_POST0: begin
        gen_byte = cmd_q.post0;
        nxt      = (cmd_q.post_cnt == 2'd2) ? SEQ_POST1 : SEQ_IDLE;
      end
      SEQ_POST1: begin
        gen_byte = cmd_q.post1;
        nxt      = SEQ_IDLE;
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase

    // Advance one byte when the byte stage can load
    if ((state_q != SEQ_IDLE) && bs_ready) begin
      gen     = 1'b1;
      state_d = nxt;
      if (state_q == SEQ_CNT) begin
        lit_idx_d = 8'd0;
        if (cmd_q.burst_len == 8'd0) begin
          burst_done_o = 1'b1;
        end
      end
      if (state_q == SEQ_LIT) begin
        lit_idx_d = lit_idx_q + 8'd1;
        if (nxt != SEQ_LIT) begin
          burst_done_o = 1'b1;
        end
      end
    end
  end

  assign re_o    = gen && gen_ram;
  assign raddr_o = lit_idx_q[LitAw-1:0];

  // Insert the incoming byte at the fill position, clear lanes above it
  always_comb begin
    merged = '0;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < acc_cnt_q) begin
        merged[8*i +: 8] = acc_word_q[8*i +: 8];
      end else if (3'(i) == acc_cnt_q) begin
        merged[8*i +: 8] = byte_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      lit_idx_q   <= 8'd0;
      bs_valid_q  <= 1'b0;
      acc_cnt_q   <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      lit_idx_q <= lit_idx_d;
      if (bs_ready) begin
        bs_valid_q <= gen;
      end
      if (byte_take) begin
        acc_cnt_q <= fin ? 3'd0 : acc_cnt_q + 3'd1;
      end
      if (byte_take && fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (bs_ready && gen) begin
      bs_ram_q  <= gen_ram;
      bs_byte_q <= gen_byte;
      bs_end_q  <= (nxt == SEQ_IDLE);
      bs_last_q <= cmd_q.last;
    end
    if (byte_take && !fin) begin
      acc_word_q <= merged;
    end
    if (byte_take && fin) begin
      out_word_q      <= merged;
      out_cnt_q       <= {1'b0, acc_cnt_q} + 4'd1;
      out_run_last_q  <= bs_end_q;
      out_block_end_q <= bs_end_q && bs_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign packed_bytes_o = out_word_q;
  assign byte_count_o   = out_cnt_q;
  assign run_last_o     = out_run_last_q;
  assign block_end_o    = out_block_end_q;

endmodule

/* rtl/core/zero_literal_run_length_encoder_unit.sv */
// Zero-run / literal-run encoder. Each accepted byte transaction is classified
// by the front end, which keeps the phase and run count and writes non-zero
// bytes into a literal store of MaxLiterals entries (no reset, no clearing
// pass). Commands for the bytes to send go through a short queue to the back
// end, which sends the encoded bytes of a command one per cycle while its output
// is not stalled (literals read from the store through a registered read port)
// and packs them up to eight per result. For each command the back end first
// loads it from the queue and then sends its encoded bytes in order; input is
// stalled while a literal burst is outstanding and when the queue is full.
// max_run is at byte address 0 of the APB port and is written by the user only
// while the block is idle; the block itself does not enforce this.
module zero_literal_run_length_encoder_unit import zlre_pkg::*; #(
  parameter int MaxLiterals = MaxLiteralsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  // Output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [63:0]       packed_bytes_o,
  output logic [3:0]        byte_count_o,
  output logic              run_last_o,
  output logic              block_end_o
);

  localparam int LitAw = (MaxLiterals > 1) ? $clog2(MaxLiterals) : 1;

  logic [7:0]       max_run_q;
  logic             push, pop, q_full, q_empty, burst_done;
  cmd_t             push_cmd, head_cmd;
  logic             front_we, ram_we, ram_re;
  logic [LitAw-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  // Register file
  assign pready = 1'b1;
  assign prdata = (paddr == AddrMaxRun) ? {24'd0, max_run_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_run_q <= MaxRunReset;
    end else if (psel && penable && pwrite && pready && (paddr == AddrMaxRun)) begin
      max_run_q <= pwdata[7:0];
    end
  end

  zlre_front #(
    .MaxLiterals(MaxLiterals)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_run_i   (max_run_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .burst_done_i(burst_done),
    .we_o        (front_we),
    .waddr_o     (ram_waddr),
    .wdata_o     (ram_wdata)
  );

  // Write the store only on accepted transactions
  assign ram_we = front_we && in_valid_i && !in_stall_o;

  zlre_ram #(
    .Width(8),
    .Depth(MaxLiterals)
  ) u_lit_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  zlre_cmd_fifo #(
    .Depth(CmdQueueDepth)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .empty_o(q_empty)
  );

  zlre_back #(
    .MaxLiterals(MaxLiterals)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_cmd_i       (head_cmd),
    .pop_o         (pop),
    .burst_done_o  (burst_done),
    .re_o          (ram_re),
    .raddr_o       (ram_raddr),
    .rdata_i       (ram_rdata),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .packed_bytes_o(packed_bytes_o),
    .byte_count_o  (byte_count_o),
    .run_last_o    (run_last_o),
    .block_end_o   (block_end_o)
  );

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
  import zlre_pkg::*;

  // One packed output word of the encoder
  typedef struct packed {
    logic [63:0] payload;
    logic [3:0]  n_bytes;
    logic        item_done;
    logic        block_done;
  } enc_word_t;

  // Directed stimulus row; typed rows carry their single expected word
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic [63:0] word;
    logic [3:0]  cnt;
  } stim_row_t;

  localparam int NumDirected = 23;
  localparam int WatchdogLimit = 4000;
  localparam int LongHoldCycles = 400;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        data_byte_i = '0;
  logic              last_byte_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [63:0]       packed_bytes_o;
  logic [3:0]        byte_count_o;
  logic              run_last_o;
  logic              block_end_o;

  // Typed expectation riding along with the input transaction
  logic              row_typed = 1'b0;
  logic [63:0]       row_word = '0;
  logic [3:0]        row_cnt = '0;

  // Encoder model state
  logic              lit_phase = 1'b0;
  logic [7:0]        run_len = '0;
  logic [7:0]        lit_mem [256];
  logic [7:0]        cap_reg = MaxRunReset;
  logic [7:0]        emitted [$];
  enc_word_t         encoded_q [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int bad_results = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_go = 1'b0;
  bit hold_used = 1'b0;

  stim_row_t directed_rows [NumDirected] = '{
    '{8'hFF, 1'b1, 1'b1, 64'h0000_0000_00FF_0100, 4'd3},
    '{8'h00, 1'b1, 1'b1, 64'h0000_0000_0000_0001, 4'd2},
    '{8'h01, 1'b1, 1'b1, 64'h0000_0000_0001_0100, 4'd3},
    '{8'h00, 1'b0, 1'b0, 64'h0, 4'd0},
    '{8'h00, 1'b0, 1'b0, 64'h0, 4'd0},
    '{8'h80, 1'b0, 1'b0, 64'h0, 4'd0},
    '{8'h7F, 1'b0, 1'b0, 64'h0, 4'd0},
    '{8'h55, 1'b0, 1'b0, 64'h0, 4'd0},
    '{8'hAA, 1'b0, 1'b0, 64'h0, 4'd0},
    '{8'h01, 1'b0, 1'b0, 64'h0, 4'd0},
    '{8'hFE, 1'b0, 1'b0, 64'h0, 4'd0},
    '{8'h02, 1'b0, 1'b0, 64'h0, 4'd0},
    '{8'h04, 1'b0, 1'b0, 64'h0, 4'd0},
    '{8'h08, 1'b0, 1'b0, 64'h0, 4'd0},
    '{8'h10, 1'b0, 1'b0, 64'h0, 4'd0},
    '{8'h00, 1'b0, 1'b0, 64'h0, 4'd0},
    '{8'h20, 1'b0, 1'b0, 64'h0, 4'd0},
    '{8'h40, 1'b0, 1'b0, 64'h0, 4'd0},
    '{8'h00, 1'b1, 1'b0, 64'h0, 4'd0},
    '{8'h00, 1'b0, 1'b0, 64'h0, 4'd0},
    '{8'hFF, 1'b1, 1'b0, 64'h0, 4'd0},
    '{8'h00, 1'b0, 1'b0, 64'h0, 4'd0},
    '{8'h00, 1'b1, 1'b0, 64'h0, 4'd0}
  };

  zero_literal_run_length_encoder_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .packed_bytes_o (packed_bytes_o),
    .byte_count_o   (byte_count_o),
    .run_last_o     (run_last_o),
    .block_end_o    (block_end_o)
  );

  always #5 clk_i = ~clk_i;

  // Emit the literal count and the buffered literals, return to zero counting
  task automatic flush_literals();
    emitted.push_back(run_len);
    for (int i = 0; i < run_len; i++) emitted.push_back(lit_mem[i]);
    lit_phase = 1'b0;
    run_len   = '0;
  endtask

  // Encode one accepted byte and queue the packed words it produces
  task automatic encode_byte(input logic [7:0] b, input logic lst, input logic typed,
                             input logic [63:0] tword, input logic [3:0] tcnt);
    int unsigned zcap;
    int unsigned lcap;
    enc_word_t   w;
    int          n;
    emitted.delete();
    zcap = (cap_reg == 8'd0) ? 1 : cap_reg;
    lcap = (zcap < MaxLiteralsDefault) ? zcap : MaxLiteralsDefault;

    if (!lit_phase) begin
      if (b == 8'd0) begin
        run_len = run_len + 8'd1;
        if (run_len >= zcap) begin
          emitted.push_back(run_len);
          lit_phase = 1'b1;
          run_len   = '0;
        end
      end else begin
        emitted.push_back(run_len);
        lit_phase  = 1'b1;
        lit_mem[0] = b;
        run_len    = 8'd1;
        if (run_len >= lcap) flush_literals();
      end
    end else if (b != 8'd0) begin
      lit_mem[run_len] = b;
      run_len = run_len + 8'd1;
      if (run_len >= lcap) flush_literals();
    end else begin
      flush_literals();
      run_len = 8'd1;
      if (run_len >= zcap) begin
        emitted.push_back(8'd1);
        lit_phase = 1'b1;
        run_len   = '0;
      end
    end

    // Close the open pair at the end of the block
    if (lst) begin
      if (!lit_phase) begin
        if (run_len > 0) begin
          emitted.push_back(run_len);
          emitted.push_back(8'd0);
        end
      end else begin
        flush_literals();
      end
      lit_phase = 1'b0;
      run_len   = '0;
    end

    if (typed) begin
      w = '{tword, tcnt, 1'b1, lst};
      encoded_q.push_back(w);
    end else begin
      n = emitted.size();
      for (int pos = 0; pos < n; pos += 8) begin
        w = '0;
        for (int i = 0; i < 8 && pos + i < n; i++) begin
          w.payload[8*i +: 8] = emitted[pos + i];
          w.n_bytes = w.n_bytes + 4'd1;
        end
        if (pos + 8 >= n) begin
          w.item_done  = 1'b1;
          w.block_done = lst;
        end
        encoded_q.push_back(w);
      end
    end
  endtask

  // Predict accepted inputs, check accepted outputs, watch for a hang
  always @(posedge clk_i) begin
    enc_word_t got;
    enc_word_t exp_w;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        encode_byte(data_byte_i, last_byte_i, row_typed, row_word, row_cnt);
      if (out_valid_o && !out_stall_i) begin
        got = '{packed_bytes_o, byte_count_o, run_last_o, block_end_o};
        if (encoded_q.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("unexpected transaction: bytes=%h count=%0d run_last=%b block_end=%b",
                     got.payload, got.n_bytes, got.item_done, got.block_done);
        end else begin
          exp_w = encoded_q.pop_front();
          if (got.payload !== exp_w.payload || got.n_bytes !== exp_w.n_bytes ||
              got.item_done !== exp_w.item_done || got.block_done !== exp_w.block_done) begin
            bad_results++;
            if (bad_results <= 10)
              $display("mismatch: bytes %h/%h count %0d/%0d run_last %b/%b block_end %b/%b",
                       exp_w.payload, got.payload, exp_w.n_bytes, got.n_bytes,
                       exp_w.item_done, got.item_done, exp_w.block_done, got.block_done);
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver stall: one long hold-off on request, otherwise random
  always @(posedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_left = LongHoldCycles;
      hold_used = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Register write: setup cycle, then access cycle until pready; read back
  task automatic reg_write(input logic [PaddrW-1:0] addr, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == AddrMaxRun) cap_reg = val[7:0];
    @(posedge clk_i);
    if (addr == AddrMaxRun && prdata[7:0] !== val[7:0]) begin
      bad_results++;
      if (bad_results <= 10)
        $display("register readback: expected %h got %h", val[7:0], prdata[7:0]);
    end
  endtask

  // Offer one byte transaction, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input logic [63:0] tword, input logic [3:0] tcnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= lst;
    row_typed   <= typed;
    row_word    <= tword;
    row_cnt     <= tcnt;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and hold until every expected word has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (encoded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Alternate zero and literal runs; a few stray bytes break the pattern
  task automatic send_runs(input int n_items, input int max_len);
    int   sent;
    int   len;
    bit   zero_kind;
    logic [7:0] b;
    logic lst;
    sent = 0;
    zero_kind = 1'($urandom_range(1));
    while (sent < n_items) begin
      len = $urandom_range(max_len, 1);
      for (int k = 0; k < len && sent < n_items; k++) begin
        if ($urandom_range(19) == 0) b = 8'($urandom_range(255));
        else if (zero_kind) b = 8'd0;
        else b = 8'($urandom_range(255, 1));
        lst = ($urandom_range(24) == 0) || (sent == n_items - 1);
        send_byte(b, lst, 1'b0, '0, '0);
        sent++;
      end
      zero_kind = !zero_kind;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows straight after reset
    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].word, directed_rows[i].cnt);
    drain();

    // Cap of ten: run past the literal limit and the zero limit
    reg_write(AddrMaxRun, 32'd10);
    for (int i = 0; i < 24; i++) send_byte(8'($urandom_range(255, 1)), 1'b0, 1'b0, '0, '0);
    for (int i = 0; i < 24; i++) send_byte(8'd0, 1'b0, 1'b0, '0, '0);
    for (int i = 0; i < 5; i++) send_byte(8'($urandom_range(255, 1)), i == 4, 1'b0, '0, '0);
    send_runs(10, 12);
    drain();

    // Smallest cap, idle sender
    reg_write(AddrMaxRun, 32'd1);
    send_idle_pct = 60;
    send_runs(15, 3);
    drain();

    // Small cap, stalling receiver; pause the sender midway until empty
    reg_write(AddrMaxRun, 32'd3);
    send_idle_pct  = 0;
    recv_stall_pct = 60;
    send_runs(8, 5);
    drain();
    send_runs(8, 5);
    drain();

    // Cap of zero behaves as one
    reg_write(AddrMaxRun, 32'd0);
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    send_runs(12, 3);
    drain();

    // Ignored register address, then a long receiver hold-off
    reg_write(3'd4, 32'd2);
    reg_write(AddrMaxRun, 32'd7);
    hold_go = 1'b1;
    send_runs(20, 10);
    drain();

    // Back to the full cap with no idling
    reg_write(AddrMaxRun, 32'd255);
    reg_write(3'd4, 32'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_runs(10, 8);
    drain();

    if (bad_results == 0 && encoded_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
